>>> rtl/assert_macros.svh
// Assertion helpers for the deframer RTL.
// Each macro checks a property on the rising edge of clk while rst is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds on every active clock edge.
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/lrdc_pkg.sv
// ----------------------------------------------------------------------------
// lrdc_pkg: shared types and constants
// Phase encoding, result codes, record magic and CRC32C byte update for the
// log record deframer.
// ----------------------------------------------------------------------------
package lrdc_pkg;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_TAIL    = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BODY_BAD = 2'd1,
    STATUS_TAIL_BAD = 2'd2
  } status_t;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_END     = 1'b1;

  localparam logic [63:0] REC_MAGIC = 64'h004B_5641_4C30_3100;
  localparam logic [31:0] CRC_POLY  = 32'h82F6_3B78;
  localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;

  localparam logic [31:0] HEADER_BYTES = 32'd12;
  localparam logic [31:0] TAIL_BYTES   = 32'd4;
  localparam logic [31:0] WINDOW_BYTES = 32'd8;
  localparam logic [31:0] CRC_FIELD_END  = 32'd4;
  localparam logic [31:0] TERM_FIELD_END = 32'd8;

  // Reflected CRC32C update for one byte, bit by bit.
  function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'h0);
    end
    return c;
  endfunction

  // Running CRC after the eight magic bytes, evaluated at elaboration.
  function automatic logic [31:0] crc32c_magic();
    logic [31:0] c;
    c = CRC_INIT;
    for (int i = 0; i < 8; i++) begin
      c = crc32c_byte(c, REC_MAGIC[8*i +: 8]);
    end
    return c;
  endfunction

  localparam logic [31:0] MAGIC_CRC = crc32c_magic();

endpackage

>>> rtl/log_record_deframer_crc32c.sv
// ----------------------------------------------------------------------------
// log_record_deframer_crc32c: CRC32C-checked log record deframer
// Usage: the input channel (in_valid, in_ready, in_byte) takes one byte of
// the log stream per request. While hunting, the block slides an 8-byte
// window until the little-endian record magic appears. It then captures the
// 12-byte header (body CRC, term, length), forwards each payload byte as a
// result with kind 0, and reads the 4-byte tail CRC. After the last tail
// byte one result with kind 1 and last 1 carries the status: ok, body CRC
// mismatch (takes priority) or tail CRC mismatch. Hunting then resumes.
// A result reaches the output channel in the cycle after its byte is taken.
// Throughput is one byte per cycle unless the output stalls; the byte-wide
// CRC32C update and the window compare are the per-cycle logic.
// The output register frees itself in the same cycle it is taken, so
// in_ready stays high while the receiver keeps up. When the receiver stalls
// with a result waiting, in_ready drops until that result is taken.
// Reset clears the phase, the window fill count and the output valid; the
// first magic can match only after eight bytes have been taken in.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module log_record_deframer_crc32c (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        kind,
  output logic [7:0]  payload_byte,
  output logic [31:0] record_term,
  output logic [31:0] rec_length,
  output logic [1:0]  status,
  output logic        last
);
  import lrdc_pkg::*;

  phase_t      phase, phase_next;
  logic [63:0] magic_window, magic_window_next;
  logic [31:0] byte_count, byte_count_next;
  logic [31:0] header_crc_field, header_crc_field_next;
  logic [31:0] term_field, term_field_next;
  logic [31:0] length_field, length_field_next;
  logic [31:0] tail_crc_field, tail_crc_field_next;
  logic [31:0] body_crc_run, body_crc_run_next;
  logic [31:0] tail_crc_run, tail_crc_run_next;

  logic        in_fire;
  logic [31:0] cnt_inc;
  logic [31:0] body_crc_upd, tail_crc_upd;
  logic        res_valid;
  logic        res_kind;
  logic [7:0]  res_byte;
  status_t     res_status;

  assign in_fire = in_valid && in_ready;
  assign in_ready = !out_valid || out_ready;
  assign cnt_inc = byte_count + 32'd1;
  assign body_crc_upd = crc32c_byte(body_crc_run, in_byte);
  assign tail_crc_upd = crc32c_byte(tail_crc_run, in_byte);

  // Next state of the parser.
  always_comb begin
    phase_next            = phase;
    magic_window_next     = magic_window;
    byte_count_next       = byte_count;
    header_crc_field_next = header_crc_field;
    term_field_next       = term_field;
    length_field_next     = length_field;
    tail_crc_field_next   = tail_crc_field;
    body_crc_run_next     = body_crc_run;
    tail_crc_run_next     = tail_crc_run;
    case (phase)
      PH_HUNT: begin
        magic_window_next = {in_byte, magic_window[63:8]};
        if (byte_count < WINDOW_BYTES) begin
          byte_count_next = cnt_inc;
        end
        if (byte_count_next >= WINDOW_BYTES && magic_window_next == REC_MAGIC) begin
          tail_crc_run_next = MAGIC_CRC;
          body_crc_run_next = CRC_INIT;
          magic_window_next = '0;
          byte_count_next   = '0;
          phase_next        = PH_HEADER;
        end
      end
      PH_HEADER: begin
        tail_crc_run_next = tail_crc_upd;
        if (byte_count < CRC_FIELD_END) begin
          header_crc_field_next = {in_byte, header_crc_field[31:8]};
        end else if (byte_count < TERM_FIELD_END) begin
          term_field_next   = {in_byte, term_field[31:8]};
          body_crc_run_next = body_crc_upd;
        end else begin
          length_field_next = {in_byte, length_field[31:8]};
          body_crc_run_next = body_crc_upd;
        end
        byte_count_next = cnt_inc;
        if (cnt_inc >= HEADER_BYTES) begin
          byte_count_next = '0;
          phase_next = (length_field_next == 32'd0) ? PH_TAIL : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        body_crc_run_next = body_crc_upd;
        tail_crc_run_next = tail_crc_upd;
        byte_count_next   = cnt_inc;
        if (cnt_inc >= length_field) begin
          byte_count_next = '0;
          phase_next      = PH_TAIL;
        end
      end
      PH_TAIL: begin
        tail_crc_field_next = {in_byte, tail_crc_field[31:8]};
        byte_count_next     = cnt_inc;
        if (cnt_inc >= TAIL_BYTES) begin
          byte_count_next   = '0;
          magic_window_next = '0;
          phase_next        = PH_HUNT;
        end
      end
      default: begin
        phase_next = PH_HUNT;
      end
    endcase
  end

  // Result produced by the byte at the input.
  always_comb begin
    res_valid  = 1'b0;
    res_kind   = KIND_PAYLOAD;
    res_byte   = 8'h00;
    res_status = STATUS_OK;
    case (phase)
      PH_PAYLOAD: begin
        res_valid = 1'b1;
        res_byte  = in_byte;
      end
      PH_TAIL: begin
        if (cnt_inc >= TAIL_BYTES) begin
          res_valid = 1'b1;
          res_kind  = KIND_END;
          if ((body_crc_run ^ CRC_INIT) != header_crc_field) begin
            res_status = STATUS_BODY_BAD;
          end else if ((tail_crc_run ^ CRC_INIT) != tail_crc_field_next) begin
            res_status = STATUS_TAIL_BAD;
          end
        end
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HUNT;
      magic_window     <= '0;
      byte_count       <= '0;
      header_crc_field <= '0;
      term_field       <= '0;
      length_field     <= '0;
      tail_crc_field   <= '0;
      body_crc_run     <= CRC_INIT;
      tail_crc_run     <= CRC_INIT;
    end else if (in_fire) begin
      phase            <= phase_next;
      magic_window     <= magic_window_next;
      byte_count       <= byte_count_next;
      header_crc_field <= header_crc_field_next;
      term_field       <= term_field_next;
      length_field     <= length_field_next;
      tail_crc_field   <= tail_crc_field_next;
      body_crc_run     <= body_crc_run_next;
      tail_crc_run     <= tail_crc_run_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= res_valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // The term and length reported are the values captured for the record.
  always_ff @(posedge clk) begin
    if (in_fire && res_valid) begin
      kind         <= res_kind;
      payload_byte <= res_byte;
      record_term  <= term_field;
      rec_length   <= length_field;
      status       <= res_status;
      last         <= res_kind;
    end
  end

  `ASSERT_NEXT(a_payload_result, in_fire && phase == PH_PAYLOAD,
    out_valid && kind == KIND_PAYLOAD, "payload byte did not produce a result")
  `ASSERT_NEXT(a_hunt_silent, in_fire && (phase == PH_HUNT || phase == PH_HEADER),
    !out_valid, "result produced while hunting or reading the header")
  `ASSERT_ALWAYS(a_last_is_end, !out_valid || last == kind,
    "last flag does not match record-end kind")
  `ASSERT_ALWAYS(a_payload_status, !out_valid || kind == KIND_END || status == STATUS_OK,
    "payload result carries a nonzero status")
  `ASSERT_ALWAYS(a_count_range,
    (phase != PH_HEADER || byte_count < HEADER_BYTES) &&
    (phase != PH_TAIL || byte_count < TAIL_BYTES),
    "byte count out of range for the current phase")

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: log_record_deframer_crc32c
// Sends a byte stream of framed records, broken magics and noise into the
// deframer with random gaps and output stalls. Every accepted byte also goes
// through a predictor of the record format; each result that the block gives
// is compared field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module testbench;
  import lrdc_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_BYTES = 560;

  typedef enum int {
    FLAW_NONE,
    FLAW_HDR_CRC,
    FLAW_TAIL_CRC,
    FLAW_BOTH_CRC,
    FLAW_PAYLOAD
  } flaw_t;

  typedef struct {
    logic        kind;
    logic [7:0]  data;
    logic [31:0] term;
    logic [31:0] length;
    logic [1:0]  status;
    logic        last;
  } rec_result_t;

  class deframe_tracker;
    phase_t      phase;
    logic [63:0] window;
    logic [31:0] count;
    logic [31:0] hdr_crc;
    logic [31:0] term;
    logic [31:0] length;
    logic [31:0] tail_field;
    logic [31:0] body_run;
    logic [31:0] tail_run;
    logic [31:0] magic_run;
    rec_result_t expected_out[$];
    int          mismatches;

    function new();
      phase      = PH_HUNT;
      window     = '0;
      count      = '0;
      hdr_crc    = '0;
      term       = '0;
      length     = '0;
      tail_field = '0;
      body_run   = CRC_INIT;
      tail_run   = CRC_INIT;
      mismatches = 0;
      magic_run  = CRC_INIT;
      for (int i = 0; i < 8; i++) magic_run = crc_feed(magic_run, REC_MAGIC[8*i +: 8]);
    endfunction

    // Reflected Castagnoli CRC, one data bit at a time, LSB first.
    static function logic [31:0] crc_feed(logic [31:0] c, logic [7:0] b);
      for (int k = 0; k < 8; k++) begin
        if (c[0] ^ b[k]) c = (c >> 1) ^ CRC_POLY;
        else c = c >> 1;
      end
      return c;
    endfunction

    function void take_byte(logic [7:0] b);
      rec_result_t r;
      case (phase)
        PH_HUNT: begin
          window = {b, window[63:8]};
          if (count < WINDOW_BYTES) count++;
          if (count >= WINDOW_BYTES && window == REC_MAGIC) begin
            tail_run = magic_run;
            body_run = CRC_INIT;
            window   = '0;
            count    = '0;
            phase    = PH_HEADER;
          end
        end
        PH_HEADER: begin
          tail_run = crc_feed(tail_run, b);
          if (count < CRC_FIELD_END) begin
            hdr_crc = {b, hdr_crc[31:8]};
          end else begin
            if (count < TERM_FIELD_END) term = {b, term[31:8]};
            else length = {b, length[31:8]};
            body_run = crc_feed(body_run, b);
          end
          count++;
          if (count >= HEADER_BYTES) begin
            count = '0;
            phase = (length == 0) ? PH_TAIL : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          body_run = crc_feed(body_run, b);
          tail_run = crc_feed(tail_run, b);
          count++;
          if (count >= length) begin
            count = '0;
            phase = PH_TAIL;
          end
          r.kind   = KIND_PAYLOAD;
          r.data   = b;
          r.term   = term;
          r.length = length;
          r.status = STATUS_OK;
          r.last   = 1'b0;
          expected_out = {expected_out, r};
        end
        PH_TAIL: begin
          tail_field = {b, tail_field[31:8]};
          count++;
          if (count >= TAIL_BYTES) begin
            // A body mismatch wins over a tail mismatch.
            if ((body_run ^ CRC_INIT) != hdr_crc) r.status = STATUS_BODY_BAD;
            else if ((tail_run ^ CRC_INIT) != tail_field) r.status = STATUS_TAIL_BAD;
            else r.status = STATUS_OK;
            r.kind   = KIND_END;
            r.data   = 8'h00;
            r.term   = term;
            r.length = length;
            r.last   = 1'b1;
            expected_out = {expected_out, r};
            count  = '0;
            window = '0;
            phase  = PH_HUNT;
          end
        end
      endcase
    endfunction

    function void compare(string what, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
      end
    endfunction

    function void check_result(logic k, logic [7:0] d, logic [31:0] t, logic [31:0] l,
                               logic [1:0] s, logic e);
      rec_result_t want;
      if (expected_out.size() == 0) begin
        mismatches++;
        $display({"%0t: unexpected result, expected none, got kind %b byte %h",
                  " term %h length %h status %0d last %b"},
                 $time, k, d, t, l, s, e);
        return;
      end
      want = expected_out.pop_front();
      compare("kind", want.kind, k);
      compare("payload_byte", want.data, d);
      compare("record_term", want.term, t);
      compare("rec_length", want.length, l);
      compare("status", want.status, s);
      compare("last", want.last, e);
    endfunction

    function int pending();
      return expected_out.size();
    endfunction
  endclass

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic [7:0]  in_byte   = 8'h00;
  logic        out_ready = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic        kind;
  logic [7:0]  payload_byte;
  logic [31:0] record_term;
  logic [31:0] rec_length;
  logic [1:0]  status;
  logic        last;

  bit idle_on    = 1'b1;
  int bytes_sent = 0;
  int cycles     = 0;
  deframe_tracker rec_tracker = new();

  log_record_deframer_crc32c i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte      (in_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .payload_byte (payload_byte),
    .record_term  (record_term),
    .rec_length   (rec_length),
    .status       (status),
    .last         (last)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) rec_tracker.take_byte(in_byte);
      if (out_valid && out_ready) begin
        rec_tracker.check_result(kind, payload_byte, record_term, rec_length, status, last);
      end
    end
  end

  // Mostly no gap, some short ones and now and then a long one.
  function automatic int pick_gap(int longest);
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, longest);
  endfunction

  initial begin
    int stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (stall == 0) stall = pick_gap(40);
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap(30);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (rec_tracker.pending() != 0) @(posedge clk);
  endtask

  task automatic send_magic_bytes(input int first, input int final_idx);
    for (int i = first; i <= final_idx; i++) send_byte(REC_MAGIC[8*i +: 8]);
  endtask

  // A record whose payload is cut short (n_payload below length) has no tail.
  task automatic send_record(input logic [31:0] term, input logic [31:0] length,
                             input int n_payload, input flaw_t flaw, input bit pause_mid);
    logic [7:0]  data[$];
    logic [7:0]  stream[$];
    logic [95:0] hdr;
    logic [31:0] body;
    logic [31:0] tail;
    logic [31:0] hcrc;
    logic [31:0] tcrc;
    for (int i = 0; i < n_payload; i++) data = {data, 8'($urandom_range(0, 255))};
    hdr  = {length, term, 32'h0};
    body = CRC_INIT;
    for (int k = 4; k < 12; k++) body = deframe_tracker::crc_feed(body, hdr[8*k +: 8]);
    foreach (data[i]) body = deframe_tracker::crc_feed(body, data[i]);
    hcrc = body ^ CRC_INIT;
    if (flaw == FLAW_HDR_CRC || flaw == FLAW_BOTH_CRC ||
        (flaw == FLAW_PAYLOAD && n_payload == 0)) begin
      hcrc ^= 32'h1 << $urandom_range(0, 31);
    end
    hdr  = {length, term, hcrc};
    tail = CRC_INIT;
    for (int k = 0; k < 8; k++) begin
      tail = deframe_tracker::crc_feed(tail, REC_MAGIC[8*k +: 8]);
      stream = {stream, REC_MAGIC[8*k +: 8]};
    end
    for (int k = 0; k < 12; k++) begin
      tail = deframe_tracker::crc_feed(tail, hdr[8*k +: 8]);
      stream = {stream, hdr[8*k +: 8]};
    end
    foreach (data[i]) tail = deframe_tracker::crc_feed(tail, data[i]);
    tcrc = tail ^ CRC_INIT;
    if (flaw == FLAW_TAIL_CRC || flaw == FLAW_BOTH_CRC) tcrc ^= 32'h1 << $urandom_range(0, 31);
    // Corrupting a payload byte after the fact breaks both checksums.
    if (flaw == FLAW_PAYLOAD && n_payload > 0) begin
      data[$urandom_range(0, n_payload - 1)] ^= 8'h01 << $urandom_range(0, 7);
    end
    foreach (data[i]) stream = {stream, data[i]};
    if (n_payload == length) begin
      for (int k = 0; k < 4; k++) stream = {stream, tcrc[8*k +: 8]};
    end
    foreach (stream[i]) begin
      if (pause_mid && i == 20 + n_payload / 2) hold_until_drained();
      send_byte(stream[i]);
    end
  endtask

  initial begin
    int          start;
    int          rec_no;
    int          len;
    int          pick;
    logic [31:0] term;
    flaw_t       flaw;

    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // The tail of a magic with a zero window behind it must not match until
    // eight bytes have come in, both after reset and after a record end.
    send_magic_bytes(1, 7);
    send_record(32'h0000_0000, 32'd0, 0, FLAW_NONE, 1'b0);
    send_magic_bytes(1, 7);
    send_record(32'hFFFF_FFFF, 32'd1, 1, FLAW_NONE, 1'b0);
    send_record($urandom, 32'd2, 2, FLAW_HDR_CRC, 1'b0);
    send_record($urandom, 32'd3, 3, FLAW_TAIL_CRC, 1'b0);
    send_record($urandom, 32'd1, 1, FLAW_BOTH_CRC, 1'b0);
    send_record($urandom, 32'd4, 4, FLAW_PAYLOAD, 1'b0);
    // A doubled first magic byte needs the one-byte slide to resync.
    send_magic_bytes(0, 0);
    send_record($urandom, 32'd0, 0, FLAW_NONE, 1'b0);

    start  = bytes_sent;
    rec_no = 0;
    while (bytes_sent < start + RANDOM_BYTES) begin
      idle_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          repeat ($urandom_range(0, 4)) send_byte(8'($urandom_range(0, 255)));
        end
        5, 6: begin
          send_magic_bytes(0, $urandom_range(0, 6));
          send_byte(8'($urandom_range(0, 255)));
        end
        7: send_magic_bytes(0, 0);
        8: send_magic_bytes(1, 7);
        default: ;
      endcase
      pick = $urandom_range(0, 99);
      if (pick < 15) len = 0;
      else if (pick < 75) len = $urandom_range(1, 16);
      else if (pick < 95) len = $urandom_range(17, 48);
      else len = $urandom_range(49, 120);
      if (rec_no == 3 && len < 4) len = 8;
      pick = $urandom_range(0, 99);
      if (pick < 60) flaw = FLAW_NONE;
      else if (pick < 70) flaw = FLAW_HDR_CRC;
      else if (pick < 80) flaw = FLAW_TAIL_CRC;
      else if (pick < 87) flaw = FLAW_BOTH_CRC;
      else if (pick < 94) flaw = FLAW_PAYLOAD;
      else flaw = FLAW_NONE;
      pick = $urandom_range(0, 9);
      if (pick == 0) term = 32'h0000_0000;
      else if (pick == 1) term = 32'hFFFF_FFFF;
      else term = $urandom;
      send_record(term, len, len, flaw, rec_no == 3);
      rec_no++;
    end

    // The largest length keeps the block in the payload phase to the end.
    idle_on = 1'b1;
    send_record($urandom, 32'hFFFF_FFFF, 40, FLAW_NONE, 1'b0);

    hold_until_drained();
    repeat (4) @(posedge clk);
    if (rec_tracker.mismatches == 0 && rec_tracker.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
